// ===== hdl/gabq_pkg.sv =====
`timescale 1ns / 1ps

package gabq_pkg;

	// Channel and field widths
	localparam int unsigned PixW   = 8;
	localparam int unsigned LevelW = 4;
	// Widest blend sum: 255*255 + 127 fits in 16 bits
	localparam int unsigned SumW   = 16;

	// Blend arithmetic constants
	localparam logic [PixW-1:0]   AlphaFull = 8'd255;
	localparam logic [SumW-1:0]   RoundBias = 16'd127;
	// Quantizer constants
	localparam logic [PixW:0]     LevelBias = 9'd8;
	localparam logic [LevelW-1:0] LevelMax  = 4'd15;
	// Low nibble of a legal panel gray
	localparam logic [PixW-1:0]   NibbleMask = 8'h0f;

	// One input pixel
	typedef struct packed {
		logic [PixW-1:0] fg_gray;
		logic [PixW-1:0] fg_alpha;
		logic [PixW-1:0] bg_gray;
		logic [PixW-1:0] fg_red;
		logic [PixW-1:0] fg_green;
		logic [PixW-1:0] fg_blue;
		logic            last_pixel;
	} in_t;

	// One result pixel
	typedef struct packed {
		logic [PixW-1:0] quant_gray;
		logic [PixW-1:0] out_red;
		logic [PixW-1:0] out_green;
		logic [PixW-1:0] out_blue;
		logic [PixW-1:0] out_opacity;
		logic            frame_rejected;
		logic            frame_end;
	} out_t;

endpackage

// ===== hdl/gray_alpha_blend_quantize.sv =====
`timescale 1ns / 1ps

// Gray alpha blend and 16-level panel quantizer. One pixel is taken per clock
// while in_stall is low. Each pixel passes an input register, then the four
// blend units (gray and three colour channels, one 8x8 multiply pair each)
// feeding the result register. A stalled result holds while one more pixel
// waits in the input register; stall on the input side follows the output
// stall combinationally. frame_rejected is sticky over a frame: it goes high
// from the first pixel whose foreground or background gray has a nonzero low
// nibble, and its value on the pixel carrying frame_end is the frame status.
// The flag clears after that pixel. rgba_enable selects colour blending
// against the nibble-expanded background with opacity 255; when clear the
// colour and opacity outputs are zero. Write rgba_enable only while idle.
module gray_alpha_blend_quantize (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	// Pixel input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  gabq_pkg::in_t         in_data,
	// Result output
	output logic                  out_valid,
	input  logic                  out_stall,
	output gabq_pkg::out_t        out_data
);

	logic                      rgba_enable_q;
	logic                      reject_seen_q;
	logic                      valid_s1;
	gabq_pkg::in_t             pix_s1;
	logic                      reject_s1;
	logic                      valid_s2;
	gabq_pkg::out_t            res_s2;

	logic                      in_accept;
	logic                      adv_s1;
	logic                      pix_reject;
	logic                      reject_now;
	logic [gabq_pkg::PixW-1:0] bg_exp;
	logic [gabq_pkg::PixW-1:0] gray_blend;
	logic [gabq_pkg::PixW-1:0] red_blend;
	logic [gabq_pkg::PixW-1:0] green_blend;
	logic [gabq_pkg::PixW-1:0] blue_blend;
	logic [gabq_pkg::PixW:0]   level_raw;
	logic [gabq_pkg::LevelW-1:0] level;
	gabq_pkg::out_t            res_next;

	// Handshake: stage 1 moves on when the result register is empty or draining
	assign adv_s1    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgba_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			rgba_enable_q <= cfg_wr_data;
		end
	end

	// Sticky reject status, updated in transaction order at acceptance
	assign pix_reject = ((in_data.fg_gray & gabq_pkg::NibbleMask) != '0) ||
	                    ((in_data.bg_gray & gabq_pkg::NibbleMask) != '0);
	assign reject_now = reject_seen_q || pix_reject;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_seen_q <= 1'b0;
		end else if (in_accept) begin
			reject_seen_q <= reject_now && !in_data.last_pixel;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1    <= in_data;
			reject_s1 <= reject_now;
		end
	end

	// Blend units
	assign bg_exp = pix_s1.bg_gray | (pix_s1.bg_gray >> 4);

	gabq_blend u_blend_gray (
		.fg    (pix_s1.fg_gray),
		.alpha (pix_s1.fg_alpha),
		.bg    (pix_s1.bg_gray),
		.blend (gray_blend)
	);

	gabq_blend u_blend_red (
		.fg    (pix_s1.fg_red),
		.alpha (pix_s1.fg_alpha),
		.bg    (bg_exp),
		.blend (red_blend)
	);

	gabq_blend u_blend_green (
		.fg    (pix_s1.fg_green),
		.alpha (pix_s1.fg_alpha),
		.bg    (bg_exp),
		.blend (green_blend)
	);

	gabq_blend u_blend_blue (
		.fg    (pix_s1.fg_blue),
		.alpha (pix_s1.fg_alpha),
		.bg    (bg_exp),
		.blend (blue_blend)
	);

	// Quantize to 16 levels, saturating at the top level
	assign level_raw = {1'b0, gray_blend} + gabq_pkg::LevelBias;

	always_comb begin
		if (level_raw[gabq_pkg::PixW:gabq_pkg::LevelW] > 5'd15) begin
			level = gabq_pkg::LevelMax;
		end else begin
			level = level_raw[gabq_pkg::PixW-1:gabq_pkg::LevelW];
		end
	end

	// Result assembly
	always_comb begin
		res_next.quant_gray     = {level, 4'b0000};
		res_next.frame_rejected = reject_s1;
		res_next.frame_end      = pix_s1.last_pixel;
		if (rgba_enable_q) begin
			res_next.out_red     = red_blend;
			res_next.out_green   = green_blend;
			res_next.out_blue    = blue_blend;
			res_next.out_opacity = gabq_pkg::AlphaFull;
		end else begin
			res_next.out_red     = '0;
			res_next.out_green   = '0;
			res_next.out_blue    = '0;
			res_next.out_opacity = '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ===== hdl/gabq_blend.sv =====
`timescale 1ns / 1ps

// Rounded 8-bit alpha blend: (fg*a + bg*(255-a) + 127) / 255
module gabq_blend (
	input  logic [gabq_pkg::PixW-1:0] fg,
	input  logic [gabq_pkg::PixW-1:0] alpha,
	input  logic [gabq_pkg::PixW-1:0] bg,
	output logic [gabq_pkg::PixW-1:0] blend
);

	logic [gabq_pkg::PixW-1:0] alpha_inv;
	logic [gabq_pkg::SumW-1:0] prod_fg;
	logic [gabq_pkg::SumW-1:0] prod_bg;
	logic [gabq_pkg::SumW-1:0] sum;
	logic [gabq_pkg::SumW-1:0] quot_raw;

	// Weighted sum, at most 65152 so no carry out of 16 bits
	assign alpha_inv = gabq_pkg::AlphaFull - alpha;
	assign prod_fg   = fg * alpha;
	assign prod_bg   = bg * alpha_inv;
	assign sum       = prod_fg + prod_bg + gabq_pkg::RoundBias;

	// Divide by 255 as (x + (x >> 8) + 1) >> 8, exact for x below 65535
	// (at most 65407 here, so 16 bits hold it)
	assign quot_raw = sum + {8'd0, sum[gabq_pkg::SumW-1:gabq_pkg::PixW]} + 16'd1;
	assign blend    = quot_raw[gabq_pkg::SumW-1:gabq_pkg::PixW];

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// Handshake pressure per phase
	typedef enum int unsigned {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	localparam int unsigned IdleHeavy   = 81;
	localparam int unsigned IdleLight   = 19;
	localparam int unsigned QuietLimit  = 2000;
	localparam int unsigned DrainCycles = 4;
	localparam int unsigned PhaseItems  = 52;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	gabq_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	gabq_pkg::out_t out_data;

	// Pixels waiting to be driven, and results still owed by the block
	gabq_pkg::in_t pending_pixels[$];
	gabq_pkg::out_t expected_pixels[$];

	// Predictor copy of the block's register and frame state
	bit rgba_on = 1'b0;
	bit frame_reject = 1'b0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned issued_count = 0;
	int unsigned results_seen = 0;
	int unsigned failures = 0;
	int unsigned quiet_cycles = 0;
	gabq_pkg::out_t want_px;

	gray_alpha_blend_quantize dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// 8-bit alpha blend with round-to-nearest divide by 255
	function automatic logic [7:0] blend_chan(logic [7:0] fg, logic [7:0] a, logic [7:0] bg);
		int unsigned f;
		int unsigned al;
		int unsigned b;
		f  = fg;
		al = a;
		b  = bg;
		return 8'((f * al + b * (255 - al) + 127) / 255);
	endfunction

	// Snap a gray to one of 16 panel levels
	function automatic logic [7:0] panel_level(logic [7:0] g);
		int unsigned lvl;
		lvl = (int'(g) + 8) / 16;
		if (lvl > 15) begin
			lvl = 15;
		end
		return 8'(lvl * 16);
	endfunction

	// Expected result of one pixel; updates the sticky frame flag
	function automatic gabq_pkg::out_t predict_pixel(gabq_pkg::in_t px);
		gabq_pkg::out_t res;
		logic [7:0] bg_wide;
		res = '0;
		if ((px.fg_gray & gabq_pkg::NibbleMask) != 0 ||
		    (px.bg_gray & gabq_pkg::NibbleMask) != 0) begin
			frame_reject = 1'b1;
		end
		res.quant_gray = panel_level(blend_chan(px.fg_gray, px.fg_alpha, px.bg_gray));
		if (rgba_on) begin
			bg_wide         = px.bg_gray | (px.bg_gray >> 4);
			res.out_red     = blend_chan(px.fg_red, px.fg_alpha, bg_wide);
			res.out_green   = blend_chan(px.fg_green, px.fg_alpha, bg_wide);
			res.out_blue    = blend_chan(px.fg_blue, px.fg_alpha, bg_wide);
			res.out_opacity = gabq_pkg::AlphaFull;
		end
		res.frame_rejected = frame_reject;
		res.frame_end      = px.last_pixel;
		if (px.last_pixel) begin
			frame_reject = 1'b0;
		end
		return res;
	endfunction

	function automatic gabq_pkg::in_t make_px(int fg, int a, int bg, int r, int g, int b,
		bit last);
		gabq_pkg::in_t px;
		px.fg_gray    = 8'(fg);
		px.fg_alpha   = 8'(a);
		px.bg_gray    = 8'(bg);
		px.fg_red     = 8'(r);
		px.fg_green   = 8'(g);
		px.fg_blue    = 8'(b);
		px.last_pixel = last;
		return px;
	endfunction

	// Legal grays have a clear low nibble; alpha leans towards its extremes
	function automatic gabq_pkg::in_t random_pixel(bit legal, bit last);
		gabq_pkg::in_t px;
		px.fg_gray  = legal ? {4'($urandom_range(0, 15)), 4'h0} : 8'($urandom_range(0, 255));
		px.bg_gray  = legal ? {4'($urandom_range(0, 15)), 4'h0} : 8'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: px.fg_alpha = 8'd0;
			1: px.fg_alpha = 8'd255;
			default: px.fg_alpha = 8'($urandom_range(0, 255));
		endcase
		px.fg_red     = 8'($urandom_range(0, 255));
		px.fg_green   = 8'($urandom_range(0, 255));
		px.fg_blue    = 8'($urandom_range(0, 255));
		px.last_pixel = last;
		return px;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	task automatic issue(gabq_pkg::in_t px);
		pending_pixels.push_back(px);
		issued_count++;
	endtask

	// Wait for every owed result, then let the pipeline settle
	task automatic drain();
		while (results_seen < issued_count) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_rgba(bit value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		rgba_on = value;
	endtask

	task automatic set_idle(idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct  = IdleHeavy;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct  = 0;
				recv_stall_pct = IdleHeavy;
			end
			default: begin
				send_idle_pct  = IdleLight;
				recv_stall_pct = IdleLight;
			end
		endcase
	endtask

	// Mostly well-formed frames, with some illegal grays and loose noise pixels
	task automatic fill_phase(int target);
		int n;
		int len;
		n = 0;
		while (n < target) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					issue(random_pixel($urandom_range(0, 99) < 92, k == len - 1));
				end
				n += len;
			end else begin
				issue(random_pixel(1'b0, 1'($urandom_range(0, 1))));
				n++;
			end
		end
	endtask

	// Driver: present the next pixel once the current transaction is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(predict_pixel(in_data));
			end
			if (!in_valid || !in_stall) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("result transaction with no pixel outstanding");
					failures++;
				end else begin
					want_px = expected_pixels.pop_front();
					check_field("quant_gray", want_px.quant_gray, out_data.quant_gray);
					check_field("out_red", want_px.out_red, out_data.out_red);
					check_field("out_green", want_px.out_green, out_data.out_green);
					check_field("out_blue", want_px.out_blue, out_data.out_blue);
					check_field("out_opacity", want_px.out_opacity, out_data.out_opacity);
					check_field("frame_rejected", 8'(want_px.frame_rejected),
						8'(out_data.frame_rejected));
					check_field("frame_end", 8'(want_px.frame_end), 8'(out_data.frame_end));
				end
				results_seen++;
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);

		// Gray path with colour off (reset value)
		issue(make_px(0, 0, 0, 0, 0, 0, 1'b0));
		issue(make_px(240, 255, 0, 255, 255, 255, 1'b0));
		issue(make_px(0, 255, 240, 255, 255, 255, 1'b0));
		issue(make_px(240, 0, 240, 0, 0, 0, 1'b0));
		issue(make_px(240, 128, 0, 128, 64, 32, 1'b1));
		// illegal grays, top level clamp, reject carried to frame end
		issue(make_px(255, 255, 255, 255, 255, 255, 1'b0));
		issue(make_px(16, 127, 32, 0, 0, 0, 1'b1));
		issue(make_px(16, 127, 32, 0, 0, 0, 1'b1));
		issue(make_px(0, 200, 15, 0, 0, 0, 1'b0));
		issue(make_px(0, 0, 0, 0, 0, 0, 1'b0));
		issue(make_px(240, 1, 16, 170, 85, 255, 1'b1));
		drain();

		// Colour path
		write_rgba(1'b1);
		issue(make_px(240, 255, 0, 255, 0, 170, 1'b0));
		issue(make_px(0, 0, 240, 0, 0, 0, 1'b0));
		issue(make_px(0, 0, 0, 255, 255, 255, 1'b0));
		issue(make_px(128, 128, 128, 85, 170, 255, 1'b0));
		issue(make_px(96, 254, 255, 1, 254, 128, 1'b0));
		issue(make_px(0, 255, 0, 0, 0, 0, 1'b1));
		issue(make_px(16, 64, 224, 255, 0, 0, 1'b1));
		drain();

		// Random phases cycling pressure and colour mode
		for (int ph = 0; ph < 8; ph++) begin
			write_rgba(ph % 2 == 1);
			set_idle(idle_mode_e'(ph % 4));
			fill_phase(PhaseItems);
			drain();
		end

		if (expected_pixels.size() != 0) begin
			$error("%0d expected results never arrived", expected_pixels.size());
			failures++;
		end
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gabq_pkg.sv
hdl/gabq_blend.sv
hdl/gray_alpha_blend_quantize.sv
tb/sv/testbench.sv
